### sv/sxd_pkg.sv
// Shared types and constants for the serial output expander driver.
`default_nettype none

package sxd_pkg;

    // Default for the largest number of chained 8-bit registers (MAX_CHAIN).
    localparam int MAX_CHAIN_DEF = 8;

    // Width of the chain length register.
    localparam int CHAIN_W = 4;

    // Number of pending apply requests held between the command and shift sides.
    localparam int QUEUE_DEPTH = 2;

    // Bits per chained register.
    localparam int REG_BITS = 8;

    typedef enum logic [2:0] {
        OP_SET_APPLY    = 3'd0,
        OP_SET          = 3'd1,
        OP_SET_ALL_APPLY = 3'd2,
        OP_SET_ALL      = 3'd3,
        OP_TOGGLE_APPLY = 3'd4,
        OP_APPLY        = 3'd5
    } opcode_t;

endpackage

`default_nettype wire

### sv/serial_output_expander_driver_top.sv
// Top level of the serial output expander driver.
//
// The block keeps a shadow image of up to MAX_CHAIN*8 output pins for a daisy
// chain of 8-bit serial-in parallel-out registers. Commands arrive on the
// in_valid/in_ready channel (opcode, pin_index, level), one command per
// transfer. Every command is handled in the cycle it is accepted; commands
// that apply the image queue a snapshot of it for the shift side.
// The shift side loads a snapshot into its single shift register, which then
// emits one bit per output transfer on out_valid/out_ready, highest pin first.
// Each snapshot is registered in the queue and then in the shift register before
// its first bit is offered. The last bit of each run (pin 0) carries latch_after.
// A two-entry request queue sits between the sides, so further commands are
// accepted while a run is in progress until two runs are pending.
// When the receiver stalls, the current bit is held in the output register
// and shifting pauses; in_ready drops only when the queue is full.
// Reset clears the pin image to all low, sets the chain length to one and empties
// the queue. The chain length, written via cfg_write_en/cfg_write_data, is clamped
// to 1..MAX_CHAIN; the user must write it only while idle, unenforced by the block.
`default_nettype none

module serial_output_expander_driver_top #(
    parameter int MAX_CHAIN = sxd_pkg::MAX_CHAIN_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write_en,
    input  wire logic [sxd_pkg::CHAIN_W-1:0] cfg_write_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [2:0]                  opcode,
    input  wire logic [5:0]                  pin_index,
    input  wire logic                        level,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             serial_data,
    output logic [5:0]                       bit_position,
    output logic                             latch_after
);
    import sxd_pkg::*;

    localparam int IMG_W   = MAX_CHAIN * REG_BITS;
    localparam int ENTRY_W = IMG_W + CHAIN_W;

    logic               push;
    logic [IMG_W-1:0]   push_img;
    logic [CHAIN_W-1:0] push_chain;
    logic               full;
    logic               empty;
    logic               pop;
    logic [ENTRY_W-1:0] pop_data;

    // The command side updates the image and raises push for each apply.
    sxd_front #(
        .MAX_CHAIN (MAX_CHAIN)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .pin_index      (pin_index),
        .level          (level),
        .full           (full),
        .push           (push),
        .push_img       (push_img),
        .push_chain     (push_chain)
    );

    // Each queue entry holds the image snapshot and the chain length in use.
    sxd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_chain, push_img}),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    // The shift side drains one request at a time into the output register.
    sxd_back #(
        .MAX_CHAIN (MAX_CHAIN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (!empty),
        .q_img        (pop_data[IMG_W-1:0]),
        .q_chain      (pop_data[ENTRY_W-1:IMG_W]),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .serial_data  (serial_data),
        .bit_position (bit_position),
        .latch_after  (latch_after)
    );

endmodule

`default_nettype wire

### sv/sxd_front.sv
// Command side: chain length register, pin image and apply request generation.
`default_nettype none

module sxd_front #(
    parameter int MAX_CHAIN = sxd_pkg::MAX_CHAIN_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_write_en,
    input  wire logic [sxd_pkg::CHAIN_W-1:0]             cfg_write_data,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic [2:0]                              opcode,
    input  wire logic [5:0]                              pin_index,
    input  wire logic                                    level,
    input  wire logic                                    full,
    output logic                                         push,
    output logic [MAX_CHAIN*sxd_pkg::REG_BITS-1:0]       push_img,
    output logic [sxd_pkg::CHAIN_W-1:0]                  push_chain
);
    import sxd_pkg::*;

    localparam int IMG_W = MAX_CHAIN * REG_BITS;

    logic [CHAIN_W-1:0] chain_reg;
    logic [CHAIN_W-1:0] chain_next;
    logic [IMG_W-1:0]   img_reg;
    logic [IMG_W-1:0]   img_next;
    logic [6:0]         total_bits;
    logic               in_range;
    logic               accept;
    logic               do_apply;

    assign in_ready   = !full;
    assign accept     = in_valid && in_ready;
    assign total_bits = {chain_reg, 3'b000};
    assign in_range   = {1'b0, pin_index} < total_bits;

    // Written values are clamped into the supported chain range.
    always_comb
    begin
        if (cfg_write_data == '0)
            chain_next = CHAIN_W'(1);
        else if (cfg_write_data > CHAIN_W'(MAX_CHAIN))
            chain_next = CHAIN_W'(MAX_CHAIN);
        else
            chain_next = cfg_write_data;
    end

    always_comb
    begin
        img_next = img_reg;
        do_apply = 1'b0;
        if (accept)
        begin
            case (opcode_t'(opcode))
                OP_SET_APPLY, OP_SET:
                begin
                    if (in_range)
                    begin
                        for (int i = 0; i < IMG_W; i++)
                        begin
                            if (pin_index == 6'(i))
                                img_next[i] = level;
                        end
                        do_apply = (opcode_t'(opcode) == OP_SET_APPLY);
                    end
                end
                OP_SET_ALL_APPLY, OP_SET_ALL:
                begin
                    for (int r = 0; r < MAX_CHAIN; r++)
                    begin
                        if (CHAIN_W'(r) < chain_reg)
                            img_next[r*REG_BITS +: REG_BITS] = {REG_BITS{level}};
                    end
                    do_apply = (opcode_t'(opcode) == OP_SET_ALL_APPLY);
                end
                OP_TOGGLE_APPLY:
                begin
                    if (in_range)
                    begin
                        for (int i = 0; i < IMG_W; i++)
                        begin
                            if (pin_index == 6'(i))
                                img_next[i] = !img_reg[i];
                        end
                        do_apply = 1'b1;
                    end
                end
                OP_APPLY:
                begin
                    do_apply = 1'b1;
                end
                default:
                begin
                    do_apply = 1'b0;
                end
            endcase
        end
    end

    assign push       = do_apply;
    assign push_img   = img_next;
    assign push_chain = chain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= CHAIN_W'(1);
            img_reg   <= '0;
        end
        else
        begin
            img_reg <= img_next;
            if (cfg_write_en)
                chain_reg <= chain_next;
        end
    end

    chain_in_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        chain_reg >= CHAIN_W'(1) && chain_reg <= CHAIN_W'(MAX_CHAIN))
        else $error("chain length register outside supported range");

    ignored_pin_no_apply_a: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_range &&
        (opcode_t'(opcode) == OP_SET_APPLY || opcode_t'(opcode) == OP_TOGGLE_APPLY)
        |-> !push)
        else $error("apply requested for a pin outside the chain");

endmodule

`default_nettype wire

### sv/sxd_queue.sv
// Short queue of pending apply requests between the command and shift sides.
`default_nettype none

module sxd_queue #(
    parameter int WIDTH = 68,
    parameter int DEPTH = sxd_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  full,
    output logic                  empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    no_overflow_a: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("apply request pushed into a full queue");

    no_underflow_a: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("apply request popped from an empty queue");

endmodule

`default_nettype wire

### sv/sxd_back.sv
// Shift side: loads an image snapshot and emits it one bit per transfer.
`default_nettype none

module sxd_back #(
    parameter int MAX_CHAIN = sxd_pkg::MAX_CHAIN_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_valid,
    input  wire logic [MAX_CHAIN*sxd_pkg::REG_BITS-1:0] q_img,
    input  wire logic [sxd_pkg::CHAIN_W-1:0]         q_chain,
    output logic                                     pop,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     serial_data,
    output logic [5:0]                               bit_position,
    output logic                                     latch_after
);
    import sxd_pkg::*;

    localparam int IMG_W = MAX_CHAIN * REG_BITS;

    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } state_t;

    state_t           state_reg;
    logic [IMG_W-1:0] sreg_reg;
    logic [5:0]       pos_reg;
    logic             out_valid_reg;
    logic             sd_reg;
    logic [5:0]       bp_reg;
    logic             la_reg;
    logic [6:0]       total_bits;
    logic [6:0]       align_amt;
    logic             out_free;

    assign total_bits = {q_chain, 3'b000};
    assign align_amt  = 7'(IMG_W) - total_bits;
    assign out_free   = !out_valid_reg || out_ready;
    assign pop        = (state_reg == ST_IDLE) && q_valid;

    assign out_valid    = out_valid_reg;
    assign serial_data  = sd_reg;
    assign bit_position = bp_reg;
    assign latch_after  = la_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sreg_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            sd_reg        <= 1'b0;
            bp_reg        <= '0;
            la_reg        <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    // The last bit of a run stays offered until it is taken.
                    if (out_valid_reg && out_ready)
                        out_valid_reg <= 1'b0;
                    if (q_valid)
                    begin
                        // Highest pin in use lands in the top bit.
                        sreg_reg  <= q_img << align_amt;
                        pos_reg   <= 6'(total_bits - 7'd1);
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        sd_reg        <= sreg_reg[IMG_W-1];
                        bp_reg        <= pos_reg;
                        la_reg        <= (pos_reg == '0);
                        sreg_reg      <= sreg_reg << 1;
                        pos_reg       <= pos_reg - 1'b1;
                        if (pos_reg == '0)
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    latch_on_pin_zero_a: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (la_reg == (bp_reg == '0)))
        else $error("latch mark does not match pin zero");

    pop_starts_shift_a: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == ST_SHIFT)
        else $error("popped request did not start a shift run");

endmodule

`default_nettype wire
